// ===== rtl/axc_pkg.sv =====
// AES-128 XTS sector cipher: shared constants, command/status types, AES helpers.
// Used by the interfaces, the sequencer, the datapath and the top level; depends on nothing.
package axc_pkg;

  localparam int SECTOR_BLOCK_BITS_DEF = 17;
  localparam int SECTOR_BLOCKS_RST = 32;
  localparam int SKIP_BITS = 60;
  localparam int CNT_W = $clog2(SKIP_BITS);
  localparam int NUM_ROUNDS = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DKEY_LO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DKEY_HI = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TKEY_LO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TKEY_HI = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SBLK = 3'd5;

  localparam logic [7:0] XTS_POLY = 8'h87;

  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_LATCH = 4'd1;
  localparam logic [3:0] OP_DIV = 4'd2;
  localparam logic [3:0] OP_SADD = 4'd3;
  localparam logic [3:0] OP_TLOAD = 4'd4;
  localparam logic [3:0] OP_TRND = 4'd5;
  localparam logic [3:0] OP_DBL = 4'd6;
  localparam logic [3:0] OP_DLOAD = 4'd7;
  localparam logic [3:0] OP_ERND = 4'd8;
  localparam logic [3:0] OP_KFWD = 4'd9;
  localparam logic [3:0] OP_DDLOAD = 4'd10;
  localparam logic [3:0] OP_DRND = 4'd11;
  localparam logic [3:0] OP_FIN = 4'd12;

  typedef struct packed {
    logic [3:0] op;
    logic [3:0] rnd;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic wrap;
    logic dbl_zero;
    logic out_free;
  } sts_t;

  localparam logic [2047:0] SBOX_TBL = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

  localparam logic [2047:0] ISBOX_TBL = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

  function automatic logic [7:0] sub_fwd(input logic [7:0] x);
    return SBOX_TBL[8*(255 - int'(x)) +: 8];
  endfunction

  function automatic logic [7:0] sub_inv(input logic [7:0] x);
    return ISBOX_TBL[8*(255 - int'(x)) +: 8];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] n);
    logic [7:0] r;
    case (n)
      4'd1: r = 8'h01;
      4'd2: r = 8'h02;
      4'd3: r = 8'h04;
      4'd4: r = 8'h08;
      4'd5: r = 8'h10;
      4'd6: r = 8'h20;
      4'd7: r = 8'h40;
      4'd8: r = 8'h80;
      4'd9: r = 8'h1b;
      4'd10: r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // byte i of a 128-bit value sits at bits [8i+7:8i]
  function automatic logic [31:0] key_core(input logic [31:0] w, input logic [7:0] rc);
    return {sub_fwd(w[7:0]), sub_fwd(w[31:24]), sub_fwd(w[23:16]), sub_fwd(w[15:8]) ^ rc};
  endfunction

  function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3;
    w0 = k[31:0] ^ key_core(k[127:96], rc);
    w1 = k[63:32] ^ w0;
    w2 = k[95:64] ^ w1;
    w3 = k[127:96] ^ w2;
    return {w3, w2, w1, w0};
  endfunction

  function automatic logic [127:0] key_inv(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3;
    w3 = k[127:96] ^ k[95:64];
    w2 = k[95:64] ^ k[63:32];
    w1 = k[63:32] ^ k[31:0];
    w0 = k[31:0] ^ key_core(w3, rc);
    return {w3, w2, w1, w0};
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [127:0] t, m;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        t[8*(k+4*c) +: 8] = sub_fwd(s[8*(k + 4*((c + k) % 4)) +: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[32*c +: 8];
      a1 = t[32*c+8 +: 8];
      a2 = t[32*c+16 +: 8];
      a3 = t[32*c+24 +: 8];
      m[32*c +: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      m[32*c+8 +: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      m[32*c+16 +: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      m[32*c+24 +: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    return last ? t : m;
  endfunction

  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [127:0] u, m;
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        u[8*(k+4*c) +: 8] = sub_inv(s[8*(k + 4*((c - k + 4) % 4)) +: 8]);
      end
    end
    u = u ^ rk;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        a[j] = u[32*c+8*j +: 8];
        x2[j] = xt(a[j]);
        x4[j] = xt(x2[j]);
        x8[j] = xt(x4[j]);
      end
      // rows of 14 11 13 9
      m[32*c +: 8] = (x8[0]^x4[0]^x2[0]) ^ (x8[1]^x2[1]^a[1]) ^ (x8[2]^x4[2]^a[2])
                     ^ (x8[3]^a[3]);
      m[32*c+8 +: 8] = (x8[0]^a[0]) ^ (x8[1]^x4[1]^x2[1]) ^ (x8[2]^x2[2]^a[2])
                       ^ (x8[3]^x4[3]^a[3]);
      m[32*c+16 +: 8] = (x8[0]^x4[0]^a[0]) ^ (x8[1]^a[1]) ^ (x8[2]^x4[2]^x2[2])
                        ^ (x8[3]^x2[3]^a[3]);
      m[32*c+24 +: 8] = (x8[0]^x2[0]^a[0]) ^ (x8[1]^x4[1]^a[1]) ^ (x8[2]^a[2])
                        ^ (x8[3]^x4[3]^x2[3]);
    end
    return last ? u : m;
  endfunction

  function automatic logic [127:0] gf_double(input logic [127:0] t);
    return {t[126:0], 1'b0} ^ {120'd0, (t[127] ? XTS_POLY : 8'h00)};
  endfunction

  function automatic logic [127:0] byte_rev(input logic [127:0] v);
    logic [127:0] r;
    for (int i = 0; i < 16; i++) begin
      r[8*i +: 8] = v[8*(15-i) +: 8];
    end
    return r;
  endfunction

endpackage

// ===== rtl/axc_if.sv =====
// Stream channel interfaces for the XTS sector cipher: input blocks and result blocks.
// Depends on axc_pkg for the skip count width.
interface axc_in_if;
  logic valid;
  logic ready;
  logic [63:0] data_lo;
  logic [63:0] data_hi;
  logic start_req;
  logic [63:0] sector_lo;
  logic [63:0] sector_hi;
  logic [axc_pkg::SKIP_BITS-1:0] skip_blocks;
  logic last_in;
  modport source (output valid, data_lo, data_hi, start_req, sector_lo, sector_hi,
                  skip_blocks, last_in, input ready);
  modport sink (input valid, data_lo, data_hi, start_req, sector_lo, sector_hi,
                skip_blocks, last_in, output ready);
endinterface

interface axc_out_if;
  logic valid;
  logic ready;
  logic [63:0] out_lo;
  logic [63:0] out_hi;
  logic last_out;
  modport source (output valid, out_lo, out_hi, last_out, input ready);
  modport sink (input valid, out_lo, out_hi, last_out, output ready);
endinterface

// ===== rtl/axc_ctrl.sv =====
// Sequencer for the XTS sector cipher: divide, tweak setup, AES rounds, result hand-off.
// Depends on axc_pkg for the command and status types.
module axc_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic start_req,
  output logic in_ready,
  input  axc_pkg::sts_t sts,
  output axc_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV = 4'd1;
  localparam logic [3:0] S_SADD = 4'd2;
  localparam logic [3:0] S_TLOAD = 4'd3;
  localparam logic [3:0] S_TRND = 4'd4;
  localparam logic [3:0] S_DBL = 4'd5;
  localparam logic [3:0] S_DLOAD = 4'd6;
  localparam logic [3:0] S_ERND = 4'd7;
  localparam logic [3:0] S_KFWD = 4'd8;
  localparam logic [3:0] S_DDLOAD = 4'd9;
  localparam logic [3:0] S_DRND = 4'd10;
  localparam logic [3:0] S_FIN = 4'd11;

  localparam logic [axc_pkg::CNT_W-1:0] DIV_LAST = axc_pkg::CNT_W'(axc_pkg::SKIP_BITS - 1);
  localparam logic [axc_pkg::CNT_W-1:0] RND_LAST = axc_pkg::CNT_W'(axc_pkg::NUM_ROUNDS);

  logic [3:0] state, state_next;
  logic [axc_pkg::CNT_W-1:0] cnt, cnt_next;
  logic from_fin, from_fin_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      from_fin <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      from_fin <= from_fin_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    from_fin_next = from_fin;
    in_ready = 1'b0;
    cmd.op = axc_pkg::OP_NONE;
    cmd.rnd = cnt[3:0];
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = axc_pkg::OP_LATCH;
          from_fin_next = 1'b0;
          cnt_next = '0;
          state_next = start_req ? S_DIV : S_DLOAD;
        end
      end
      S_DIV: begin
        cmd.op = axc_pkg::OP_DIV;
        cnt_next = cnt + 1'b1;
        if (cnt == DIV_LAST) state_next = S_SADD;
      end
      S_SADD: begin
        cmd.op = axc_pkg::OP_SADD;
        state_next = S_TLOAD;
      end
      S_TLOAD: begin
        cmd.op = axc_pkg::OP_TLOAD;
        cnt_next = axc_pkg::CNT_W'(1);
        state_next = S_TRND;
      end
      S_TRND: begin
        cmd.op = axc_pkg::OP_TRND;
        cnt_next = cnt + 1'b1;
        if (cnt == RND_LAST) state_next = from_fin ? S_IDLE : S_DBL;
      end
      S_DBL: begin
        if (sts.dbl_zero) begin
          state_next = S_DLOAD;
        end else begin
          cmd.op = axc_pkg::OP_DBL;
        end
      end
      S_DLOAD: begin
        cmd.op = axc_pkg::OP_DLOAD;
        cnt_next = axc_pkg::CNT_W'(1);
        state_next = sts.mode ? S_ERND : S_KFWD;
      end
      S_ERND: begin
        cmd.op = axc_pkg::OP_ERND;
        cnt_next = cnt + 1'b1;
        if (cnt == RND_LAST) state_next = S_FIN;
      end
      S_KFWD: begin
        cmd.op = axc_pkg::OP_KFWD;
        cnt_next = cnt + 1'b1;
        if (cnt == RND_LAST) state_next = S_DDLOAD;
      end
      S_DDLOAD: begin
        cmd.op = axc_pkg::OP_DDLOAD;
        cnt_next = axc_pkg::CNT_W'(1);
        state_next = S_DRND;
      end
      S_DRND: begin
        cmd.op = axc_pkg::OP_DRND;
        cnt_next = cnt + 1'b1;
        if (cnt == RND_LAST) state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.op = axc_pkg::OP_FIN;
          if (sts.wrap) begin
            from_fin_next = 1'b1;
            state_next = S_TLOAD;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/axc_dp.sv =====
// Datapath for the XTS sector cipher: config registers, skip divider, tweak and sector
// state, shared AES round unit with on-the-fly key schedule, result register.
// Depends on axc_pkg.
module axc_dp #(
  parameter int SECTOR_BLOCK_BITS = axc_pkg::SECTOR_BLOCK_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_wr_en,
  input  logic [axc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [axc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [63:0] data_lo,
  input  logic [63:0] data_hi,
  input  logic start_req,
  input  logic [63:0] sector_lo,
  input  logic [63:0] sector_hi,
  input  logic [axc_pkg::SKIP_BITS-1:0] skip_blocks,
  input  logic last_in,
  input  axc_pkg::cmd_t cmd,
  output axc_pkg::sts_t sts,
  output logic out_valid,
  input  logic out_ready,
  output logic [63:0] out_lo,
  output logic [63:0] out_hi,
  output logic last_out
);

  localparam int SB = SECTOR_BLOCK_BITS;
  localparam int QW = axc_pkg::SKIP_BITS;

  logic mode;
  logic [127:0] dkey, tkey;
  logic [SB-1:0] sblk;

  logic [127:0] xin;
  logic last_r;
  logic [127:0] sector;
  logic [127:0] tweak;
  logic [SB-1:0] bis, dcnt;
  logic [QW-1:0] quo;
  logic [SB-1:0] rem;
  logic [127:0] st, key;

  logic [SB-1:0] size, bis_inc;
  logic wrap;
  logic [SB:0] rtmp, rsub;
  logic rge;
  logic last_rnd;
  logic [127:0] key_nf, key_nb, enc_nxt, dec_nxt;

  assign size = (sblk == '0) ? SB'(1) : sblk;
  assign bis_inc = bis + SB'(1);
  assign wrap = (bis_inc >= size);
  assign rtmp = {rem, quo[QW-1]};
  assign rge = (rtmp >= {1'b0, size});
  assign rsub = rtmp - {1'b0, size};
  assign last_rnd = (cmd.rnd == 4'(axc_pkg::NUM_ROUNDS));
  assign key_nf = axc_pkg::key_fwd(key, axc_pkg::rcon(cmd.rnd));
  assign key_nb = axc_pkg::key_inv(key, axc_pkg::rcon(4'(axc_pkg::NUM_ROUNDS + 1) - cmd.rnd));
  assign enc_nxt = axc_pkg::enc_round(st, last_rnd) ^ key_nf;
  assign dec_nxt = axc_pkg::dec_round(st, key_nb, last_rnd);

  assign sts.mode = mode;
  assign sts.wrap = wrap;
  assign sts.dbl_zero = (dcnt == '0);
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      dkey <= '0;
      tkey <= '0;
      sblk <= SB'(axc_pkg::SECTOR_BLOCKS_RST);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        axc_pkg::CFG_MODE: mode <= cfg_wdata[0];
        axc_pkg::CFG_DKEY_LO: dkey[63:0] <= cfg_wdata;
        axc_pkg::CFG_DKEY_HI: dkey[127:64] <= cfg_wdata;
        axc_pkg::CFG_TKEY_LO: tkey[63:0] <= cfg_wdata;
        axc_pkg::CFG_TKEY_HI: tkey[127:64] <= cfg_wdata;
        axc_pkg::CFG_SBLK: sblk <= cfg_wdata[SB-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sector <= '0;
      tweak <= '0;
      bis <= '0;
      dcnt <= '0;
    end else begin
      case (cmd.op)
        axc_pkg::OP_LATCH: begin
          if (start_req) sector <= {sector_hi, sector_lo};
        end
        axc_pkg::OP_SADD: begin
          sector <= sector + {{(128-QW){1'b0}}, quo};
          bis <= rem;
          dcnt <= rem;
        end
        axc_pkg::OP_TRND: begin
          if (last_rnd) tweak <= enc_nxt;
        end
        axc_pkg::OP_DBL: begin
          tweak <= axc_pkg::gf_double(tweak);
          dcnt <= dcnt - SB'(1);
        end
        axc_pkg::OP_FIN: begin
          tweak <= axc_pkg::gf_double(tweak);
          if (wrap) begin
            bis <= '0;
            sector <= sector + 128'd1;
          end else begin
            bis <= bis_inc;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      axc_pkg::OP_LATCH: begin
        xin <= {data_hi, data_lo};
        last_r <= last_in;
        quo <= skip_blocks;
        rem <= '0;
      end
      axc_pkg::OP_DIV: begin
        rem <= rge ? rsub[SB-1:0] : rtmp[SB-1:0];
        quo <= {quo[QW-2:0], rge};
      end
      axc_pkg::OP_TLOAD: begin
        st <= axc_pkg::byte_rev(sector) ^ tkey;
        key <= tkey;
      end
      axc_pkg::OP_TRND, axc_pkg::OP_ERND: begin
        st <= enc_nxt;
        key <= key_nf;
      end
      axc_pkg::OP_DLOAD: begin
        st <= xin ^ tweak ^ dkey;
        key <= dkey;
      end
      axc_pkg::OP_KFWD: key <= key_nf;
      axc_pkg::OP_DDLOAD: st <= xin ^ tweak ^ key;
      axc_pkg::OP_DRND: begin
        st <= dec_nxt;
        key <= key_nb;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == axc_pkg::OP_FIN) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == axc_pkg::OP_FIN) begin
      {out_hi, out_lo} <= st ^ tweak;
      last_out <= last_r;
    end
  end

endmodule

// ===== rtl/aes128_xts_sector_crypt.sv =====
// AES-128 XTS sector cipher top level: joins the sequencer and the datapath.
// Depends on axc_pkg, axc_if, axc_ctrl, axc_dp.
//
// Usage: blocks of 16 bytes arrive on in_ch and leave on out_ch, one result per
// block, in order. A block with start_req set loads the starting sector and skip
// count; others continue from the current tweak and sector. The user must send
// configuration via cfg_wr_en/cfg_index/cfg_wdata only while idle (unenforced).
// Steps per block, one transaction at a time:
//   plain block, encrypt: load, AES rounds, hand-off; decrypt: load, key schedule
//   run forward first, then ten inverse rounds, hand-off. The shared
//   one-round-per-cycle AES unit runs every round.
//   start block first does the skip divide (one quotient bit per cycle), the
//   sector add and tweak encryption, and one tweak doubling per remaining
//   skipped block.
//   a block that ends a sector then re-encrypts the tweak for the new sector.
// Reset clears the tweak, sector and position, and sets the keys to zero, mode
// to decrypt and the sector size to 32 blocks. A finished result sits in an
// output register; the next block is taken in meanwhile and waits only at its
// hand-off stage if the receiver still stalls.
module aes128_xts_sector_crypt #(
  parameter int SECTOR_BLOCK_BITS = axc_pkg::SECTOR_BLOCK_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_wr_en,
  input  logic [axc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [axc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  axc_in_if.sink in_ch,
  axc_out_if.source out_ch
);

  axc_pkg::cmd_t cmd;
  axc_pkg::sts_t sts;

  axc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .start_req (in_ch.start_req),
    .in_ready  (in_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  axc_dp #(
    .SECTOR_BLOCK_BITS (SECTOR_BLOCK_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .data_lo     (in_ch.data_lo),
    .data_hi     (in_ch.data_hi),
    .start_req   (in_ch.start_req),
    .sector_lo   (in_ch.sector_lo),
    .sector_hi   (in_ch.sector_hi),
    .skip_blocks (in_ch.skip_blocks),
    .last_in     (in_ch.last_in),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_lo      (out_ch.out_lo),
    .out_hi      (out_ch.out_hi),
    .last_out    (out_ch.last_out)
  );

endmodule

// ===== rtl/axc_chk.sv =====
// Port-level checks for the XTS sector cipher, bound to the top level.
// Depends only on the top level's ports.
module axc_chk (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [63:0] out_lo,
  input logic [63:0] out_hi
);

  a_rst_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_lo) && $stable(out_hi))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result without processing time");

endmodule

bind aes128_xts_sector_crypt axc_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_lo    (out_ch.out_lo),
  .out_hi    (out_ch.out_hi)
);

// ===== test/tb_aes128_xts_sector_crypt.sv =====
// Testbench for aes128_xts_sector_crypt: random and directed XTS block traffic
// checked against a built-in AES-128/XTS predictor through a scoreboard class.
// Depends on axc_pkg, axc_if and the RTL of aes128_xts_sector_crypt.
module tb_aes128_xts_sector_crypt;

  typedef struct {
    logic [63:0] data_lo;
    logic [63:0] data_hi;
    logic        start;
    logic [63:0] sector_lo;
    logic [63:0] sector_hi;
    logic [59:0] skip;
    logic        last;
  } blk_in_t;

  typedef struct {
    logic [63:0] lo;
    logic [63:0] hi;
    logic        last;
  } blk_out_t;

  // indexes outside the register map
  localparam logic [axc_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [axc_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  class xts_scoreboard;
    logic [7:0]   fwd[256];
    logic [7:0]   inv[256];
    logic         mode;
    logic [63:0]  dk_lo, dk_hi, tk_lo, tk_hi;
    logic [16:0]  sect_size;
    logic [127:0] drk[11];
    logic [127:0] trk[11];
    logic [127:0] tweak, sector;
    logic [16:0]  blk_pos;
    blk_out_t     pending[$];
    int           errors;
    int           checked;

    function logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
      logic [7:0] r;
      r = 0;
      for (int i = 0; i < 8; i++) begin
        if (b[i]) r ^= a;
        a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return r;
    endfunction

    function logic [7:0] rotl(logic [7:0] v, int n);
      return (v << n) | (v >> (8 - n));
    endfunction

    function new();
      logic [7:0] v;
      for (int i = 0; i < 256; i++) begin
        v = 0;
        for (int j = 1; j < 256; j++) if (gmul(8'(i), 8'(j)) == 8'd1) v = 8'(j);
        fwd[i] = v ^ rotl(v, 1) ^ rotl(v, 2) ^ rotl(v, 3) ^ rotl(v, 4) ^ 8'h63;
      end
      for (int i = 0; i < 256; i++) inv[fwd[i]] = 8'(i);
      mode = 0;
      dk_lo = 0; dk_hi = 0; tk_lo = 0; tk_hi = 0;
      sect_size = 17'(axc_pkg::SECTOR_BLOCKS_RST);
      tweak = 0; sector = 0; blk_pos = 0;
      errors = 0; checked = 0;
      expand({dk_hi, dk_lo}, 0);
      expand({tk_hi, tk_lo}, 1);
    endfunction

    function void expand(logic [127:0] key, bit tw);
      logic [7:0] w[176];
      logic [7:0] t[4];
      logic [7:0] tmp, rc;
      rc = 8'h01;
      for (int i = 0; i < 16; i++) w[i] = key[8*i +: 8];
      for (int i = 4; i < 44; i++) begin
        for (int j = 0; j < 4; j++) t[j] = w[4*(i-1)+j];
        if (i % 4 == 0) begin
          tmp = t[0];
          t[0] = fwd[t[1]] ^ rc;
          t[1] = fwd[t[2]];
          t[2] = fwd[t[3]];
          t[3] = fwd[tmp];
          rc = gmul(rc, 2);
        end
        for (int j = 0; j < 4; j++) w[4*i+j] = w[4*(i-4)+j] ^ t[j];
      end
      for (int r = 0; r < 11; r++)
        for (int i = 0; i < 16; i++)
          if (tw) trk[r][8*i +: 8] = w[16*r+i];
          else drk[r][8*i +: 8] = w[16*r+i];
    endfunction

    function logic [127:0] aes_enc(logic [127:0] s, bit tw);
      logic [127:0] t;
      logic [7:0] a0, a1, a2, a3;
      s ^= tw ? trk[0] : drk[0];
      for (int r = 1; r <= 10; r++) begin
        for (int c = 0; c < 4; c++)
          for (int k = 0; k < 4; k++)
            t[8*(k+4*c) +: 8] = fwd[s[8*(k + 4*((c+k) % 4)) +: 8]];
        if (r < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = t[32*c +: 8]; a1 = t[32*c+8 +: 8];
            a2 = t[32*c+16 +: 8]; a3 = t[32*c+24 +: 8];
            s[32*c +: 8]    = gmul(a0, 2) ^ gmul(a1, 3) ^ a2 ^ a3;
            s[32*c+8 +: 8]  = a0 ^ gmul(a1, 2) ^ gmul(a2, 3) ^ a3;
            s[32*c+16 +: 8] = a0 ^ a1 ^ gmul(a2, 2) ^ gmul(a3, 3);
            s[32*c+24 +: 8] = gmul(a0, 3) ^ a1 ^ a2 ^ gmul(a3, 2);
          end
        end else s = t;
        s ^= tw ? trk[r] : drk[r];
      end
      return s;
    endfunction

    function logic [127:0] aes_dec(logic [127:0] s);
      logic [127:0] t;
      logic [7:0] a0, a1, a2, a3;
      s ^= drk[10];
      for (int r = 9; r >= 0; r--) begin
        for (int c = 0; c < 4; c++)
          for (int k = 0; k < 4; k++)
            t[8*(k+4*c) +: 8] = inv[s[8*(k + 4*((c-k+4) % 4)) +: 8]];
        s = t ^ drk[r];
        if (r > 0) begin
          for (int c = 0; c < 4; c++) begin
            a0 = s[32*c +: 8]; a1 = s[32*c+8 +: 8];
            a2 = s[32*c+16 +: 8]; a3 = s[32*c+24 +: 8];
            s[32*c +: 8]    = gmul(a0, 14) ^ gmul(a1, 11) ^ gmul(a2, 13) ^ gmul(a3, 9);
            s[32*c+8 +: 8]  = gmul(a0, 9) ^ gmul(a1, 14) ^ gmul(a2, 11) ^ gmul(a3, 13);
            s[32*c+16 +: 8] = gmul(a0, 13) ^ gmul(a1, 9) ^ gmul(a2, 14) ^ gmul(a3, 11);
            s[32*c+24 +: 8] = gmul(a0, 11) ^ gmul(a1, 13) ^ gmul(a2, 9) ^ gmul(a3, 14);
          end
        end
      end
      return s;
    endfunction

    function void double_tweak();
      tweak = {tweak[126:0], 1'b0} ^ {120'd0, (tweak[127] ? 8'h87 : 8'h00)};
    endfunction

    // sector number goes in as big-endian bytes
    function void load_tweak();
      logic [127:0] b;
      for (int i = 0; i < 16; i++) b[8*i +: 8] = sector[8*(15-i) +: 8];
      tweak = aes_enc(b, 1);
    endfunction

    function void set_reg(logic [axc_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
      case (idx)
        axc_pkg::CFG_MODE: mode = val[0];
        axc_pkg::CFG_DKEY_LO: begin dk_lo = val; expand({dk_hi, dk_lo}, 0); end
        axc_pkg::CFG_DKEY_HI: begin dk_hi = val; expand({dk_hi, dk_lo}, 0); end
        axc_pkg::CFG_TKEY_LO: begin tk_lo = val; expand({tk_hi, tk_lo}, 1); end
        axc_pkg::CFG_TKEY_HI: begin tk_hi = val; expand({tk_hi, tk_lo}, 1); end
        axc_pkg::CFG_SBLK: sect_size = val[16:0];
        default: ;
      endcase
    endfunction

    function void note_input(blk_in_t it);
      logic [16:0] size;
      logic [127:0] y;
      blk_out_t r;
      size = (sect_size == 0) ? 17'd1 : sect_size;
      if (it.start) begin
        sector = {it.sector_hi, it.sector_lo} + 128'(it.skip / size);
        blk_pos = 17'(it.skip % size);
        load_tweak();
        for (int k = 0; k < blk_pos; k++) double_tweak();
      end
      y = {it.data_hi, it.data_lo} ^ tweak;
      y = mode ? aes_enc(y, 0) : aes_dec(y);
      y ^= tweak;
      r.lo = y[63:0]; r.hi = y[127:64]; r.last = it.last;
      pending.push_back(r);
      double_tweak();
      blk_pos = blk_pos + 17'd1;
      if (blk_pos >= size) begin
        blk_pos = 0;
        sector = sector + 128'd1;
        load_tweak();
      end
    endfunction

    function void check_result(blk_out_t got);
      blk_out_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result lo=%h hi=%h last=%b", $time, got.lo, got.hi, got.last);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.lo !== e.lo) begin
        $display("%0t: out_lo expected %h actual %h", $time, e.lo, got.lo);
        errors++;
      end
      if (got.hi !== e.hi) begin
        $display("%0t: out_hi expected %h actual %h", $time, e.hi, got.hi);
        errors++;
      end
      if (got.last !== e.last) begin
        $display("%0t: last_out expected %b actual %b", $time, e.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [axc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [axc_pkg::CFG_DATA_W-1:0] cfg_wdata;
  axc_in_if in_ch();
  axc_out_if out_ch();

  aes128_xts_sector_crypt dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch)
  );

  localparam int WATCHDOG_LIMIT = 300000;

  xts_scoreboard sb;
  bit quiet;
  int sent;
  int stall_left;
  int idle_cycles;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst = 1;
    cfg_wr_en = 0;
    cfg_index = axc_pkg::CFG_MODE;
    cfg_wdata = 0;
    in_ch.valid = 0;
    in_ch.data_lo = 0;
    in_ch.data_hi = 0;
    in_ch.start_req = 0;
    in_ch.sector_lo = 0;
    in_ch.sector_hi = 0;
    in_ch.skip_blocks = 0;
    in_ch.last_in = 0;
    out_ch.ready = 0;
  end

  // result side
  initial begin
    blk_out_t got;
    stall_left = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (stall_left > 0) begin
        out_ch.ready = 0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 0;
        stall_left = $urandom_range(0, 5);
      end else out_ch.ready = 1;
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got.lo = out_ch.out_lo; got.hi = out_ch.out_hi; got.last = out_ch.last_out;
        sb.check_result(got);
        idle_cycles = 0;
      end
      @(negedge clk);
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      idle_cycles++;
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("aes128_xts_sector_crypt test failed");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [59:0] gen_skip(logic [16:0] size);
    logic [16:0] s;
    s = (size == 0) ? 17'd1 : size;
    if (s <= 64) return ($urandom_range(0, 1) == 0) ? 60'(rand64()) : 60'($urandom_range(0, 200));
    return 60'(rand64() % 64'h800_0000_0000) * 60'(s) + 60'($urandom_range(0, 3));
  endfunction

  task automatic send_block(blk_in_t it);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_ch.valid = 1;
    in_ch.data_lo = it.data_lo;
    in_ch.data_hi = it.data_hi;
    in_ch.start_req = it.start;
    in_ch.sector_lo = it.sector_lo;
    in_ch.sector_hi = it.sector_hi;
    in_ch.skip_blocks = it.skip;
    in_ch.last_in = it.last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(it);
    idle_cycles = 0;
    sent++;
    @(negedge clk);
  endtask

  // all results back and the block idle again
  task automatic wait_drained();
    while (sb.pending.size() != 0 || !in_ch.ready) @(negedge clk);
  endtask

  task automatic write_reg(logic [axc_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_wr_en = 1;
    cfg_index = idx;
    cfg_wdata = val;
    sb.set_reg(idx, val);
  endtask

  task automatic configure(logic m, logic [127:0] dk, logic [127:0] tk, logic [16:0] size);
    in_ch.valid = 0;
    wait_drained();
    write_reg(axc_pkg::CFG_MODE, {63'd0, m});
    write_reg(axc_pkg::CFG_DKEY_LO, dk[63:0]);
    write_reg(axc_pkg::CFG_DKEY_HI, dk[127:64]);
    write_reg(axc_pkg::CFG_TKEY_LO, tk[63:0]);
    write_reg(axc_pkg::CFG_TKEY_HI, tk[127:64]);
    write_reg(axc_pkg::CFG_SBLK, {47'd0, size});
    @(negedge clk);
    cfg_wr_en = 0;
  endtask

  task automatic directed(logic [16:0] size);
    blk_in_t it;
    it = '{64'd0, 64'd0, 1'b0, 64'd0, 64'd0, 60'd0, 1'b0};
    send_block(it);
    it.data_lo = '1; it.data_hi = '1; it.last = 1;
    send_block(it);
    it = '{64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1, '1, '1, 60'd0, 1'b0};
    send_block(it);
    it.start = 0;
    for (int i = 0; i < 4; i++) send_block(it);
    it.start = 1; it.skip = (size <= 64) ? '1 : 60'(size) - 60'd1; it.last = 1;
    send_block(it);
    it = '{64'd1, 64'h8000000000000000, 1'b1, 64'hffffffffffffffff, 64'd0, 60'd0, 1'b1};
    send_block(it);
    it.sector_lo = 0; it.sector_hi = 64'h8000000000000000; it.skip = 60'd1;
    send_block(it);
  endtask

  task automatic random_traffic(int count, logic [16:0] size, bit hold_off);
    blk_in_t it;
    int n, run;
    n = 0;
    while (n < count) begin
      if (hold_off && n >= count / 2) begin
        in_ch.valid = 0;
        wait_drained();
        hold_off = 0;
      end
      if ($urandom_range(0, 9) < 8) begin
        run = (size != 0 && size <= 64) ? $urandom_range(1, 3 * size) : $urandom_range(1, 8);
        if (run > 40) run = 40;
        for (int k = 0; k < run; k++) begin
          it.data_lo = rand64(); it.data_hi = rand64();
          it.start = (k == 0);
          it.sector_lo = ($urandom_range(0, 4) == 0) ? ~64'($urandom_range(0, 3)) : rand64();
          it.sector_hi = ($urandom_range(0, 4) == 0) ? '1 : rand64();
          it.skip = gen_skip(size);
          it.last = (k == run - 1);
          send_block(it);
          n++;
        end
      end else begin
        it.data_lo = rand64(); it.data_hi = rand64();
        it.start = $urandom_range(0, 1);
        it.sector_lo = rand64(); it.sector_hi = rand64();
        it.skip = gen_skip(size);
        it.last = $urandom_range(0, 1);
        send_block(it);
        n++;
      end
    end
  endtask

  initial begin
    logic [16:0] size;
    sb = new();
    quiet = 0;
    sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;
    directed(17'd32);
    random_traffic(100, 17'd32, 0);
    configure(1, '1, '1, 17'd1);
    directed(17'd1);
    random_traffic(100, 17'd1, 1);
    configure(0, {rand64(), rand64()}, {rand64(), rand64()}, 17'd65536);
    directed(17'd65536);
    random_traffic(60, 17'd65536, 0);
    configure(1, {rand64(), rand64()}, {rand64(), rand64()}, 17'd65535);
    random_traffic(60, 17'd65535, 0);
    configure(1, 0, 0, 17'd0);
    random_traffic(80, 17'd0, 0);
    // index outside the register map must be ignored
    in_ch.valid = 0;
    wait_drained();
    write_reg(CFG_SPARE_A, rand64());
    write_reg(CFG_SPARE_B, rand64());
    @(negedge clk);
    cfg_wr_en = 0;
    random_traffic(20, 17'd0, 0);
    for (int p = 0; p < 8; p++) begin
      size = (p == 7) ? 17'd32 : 17'($urandom_range(1, 40));
      configure(p[0], {rand64(), rand64()}, {rand64(), rand64()}, size);
      if (p == 6) quiet = 1;
      random_traffic(110, size, p == 2);
    end
    in_ch.valid = 0;
    wait_drained();
    repeat (40) @(posedge clk);
    $display("sent %0d blocks, checked %0d results over 13 key/mode/sector-size settings",
             sent, sb.checked);
    $display("sector sizes 0, 1, 65535, 65536 and random; both directions; sector wrap");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("aes128_xts_sector_crypt test passed");
    end else begin
      $display("aes128_xts_sector_crypt test failed");
    end
    $finish;
  end
endmodule
